/* rtl/ss1kd_pkg.sv */
`default_nettype none

package ss1kd_pkg;

    // scan byte codes
    localparam logic [7:0] PREFIX_BYTE = 8'hE0;
    localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT  = 7'h36;
    localparam logic [6:0] KEY_CAPS    = 7'h3A;
    localparam logic [6:0] KEY_UP      = 7'h48;
    localparam logic [6:0] KEY_DOWN    = 7'h50;
    localparam logic [6:0] KEY_LEFT    = 7'h4B;
    localparam logic [6:0] KEY_RIGHT   = 7'h4D;
    localparam logic [6:0] KEY_HOME    = 7'h47;
    localparam logic [6:0] KEY_END     = 7'h4F;
    localparam logic [6:0] KEY_DELETE  = 7'h53;

    // lower-case letter bounds
    localparam logic [6:0] CHAR_LOW_A  = 7'h61;
    localparam logic [6:0] CHAR_LOW_Z  = 7'h7A;
    localparam logic [6:0] CHAR_NONE   = 7'h00;

    typedef enum logic [2:0] {
        EV_CHAR   = 3'd0,
        EV_UP     = 3'd1,
        EV_DOWN   = 3'd2,
        EV_LEFT   = 3'd3,
        EV_RIGHT  = 3'd4,
        EV_HOME   = 3'd5,
        EV_END    = 3'd6,
        EV_DELETE = 3'd7
    } event_t;

    // one result word plus its valid flag
    typedef struct packed {
        logic       valid;
        event_t     event_code;
        logic [6:0] char_code;
    } result_t;

    // us layout, unshifted; zero means unmapped
    function automatic logic [6:0] key_char(input logic [6:0] key);
        logic [6:0] c;
        unique case (key)
            7'h02: c = 7'h31;  // 1
            7'h03: c = 7'h32;
            7'h04: c = 7'h33;
            7'h05: c = 7'h34;
            7'h06: c = 7'h35;
            7'h07: c = 7'h36;
            7'h08: c = 7'h37;
            7'h09: c = 7'h38;
            7'h0A: c = 7'h39;
            7'h0B: c = 7'h30;  // 0
            7'h0C: c = 7'h2D;  // -
            7'h0D: c = 7'h3D;  // =
            7'h0E: c = 7'h08;  // backspace
            7'h0F: c = 7'h09;  // tab
            7'h10: c = 7'h71;  // q
            7'h11: c = 7'h77;
            7'h12: c = 7'h65;
            7'h13: c = 7'h72;
            7'h14: c = 7'h74;
            7'h15: c = 7'h79;
            7'h16: c = 7'h75;
            7'h17: c = 7'h69;
            7'h18: c = 7'h6F;
            7'h19: c = 7'h70;  // p
            7'h1A: c = 7'h5B;  // [
            7'h1B: c = 7'h5D;  // ]
            7'h1C: c = 7'h0A;  // enter
            7'h1E: c = 7'h61;  // a
            7'h1F: c = 7'h73;
            7'h20: c = 7'h64;
            7'h21: c = 7'h66;
            7'h22: c = 7'h67;
            7'h23: c = 7'h68;
            7'h24: c = 7'h6A;
            7'h25: c = 7'h6B;
            7'h26: c = 7'h6C;  // l
            7'h27: c = 7'h3B;  // ;
            7'h28: c = 7'h27;  // quote
            7'h29: c = 7'h60;  // backtick
            7'h2B: c = 7'h5C;  // backslash
            7'h2C: c = 7'h7A;  // z
            7'h2D: c = 7'h78;
            7'h2E: c = 7'h63;
            7'h2F: c = 7'h76;
            7'h30: c = 7'h62;
            7'h31: c = 7'h6E;
            7'h32: c = 7'h6D;  // m
            7'h33: c = 7'h2C;  // ,
            7'h34: c = 7'h2E;  // .
            7'h35: c = 7'h2F;  // /
            7'h37: c = 7'h2A;  // keypad *
            7'h39: c = 7'h20;  // space
            7'h4A: c = 7'h2D;  // keypad -
            7'h4E: c = 7'h2B;  // keypad +
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

    // us shifted form of digits and punctuation
    function automatic logic [6:0] shifted_char(input logic [6:0] c);
        logic [6:0] s;
        unique case (c)
            7'h31: s = 7'h21;
            7'h32: s = 7'h40;
            7'h33: s = 7'h23;
            7'h34: s = 7'h24;
            7'h35: s = 7'h25;
            7'h36: s = 7'h5E;
            7'h37: s = 7'h26;
            7'h38: s = 7'h2A;
            7'h39: s = 7'h28;
            7'h30: s = 7'h29;
            7'h2D: s = 7'h5F;
            7'h3D: s = 7'h2B;
            7'h5B: s = 7'h7B;
            7'h5D: s = 7'h7D;
            7'h5C: s = 7'h7C;
            7'h3B: s = 7'h3A;
            7'h27: s = 7'h22;
            7'h2C: s = 7'h3C;
            7'h2E: s = 7'h3E;
            7'h2F: s = 7'h3F;
            7'h60: s = 7'h7E;
            default: s = c;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/ss1kd_lookup.sv */
`default_nettype none

module ss1kd_lookup (
    input  wire logic [6:0] key,
    input  wire logic       shift_held,
    input  wire logic       caps_on,
    output logic      [6:0] char_code
);
    import ss1kd_pkg::*;

    logic [6:0] base_char;
    logic       is_letter;

    always_comb
    begin
        base_char = key_char(key);
        is_letter = (base_char >= CHAR_LOW_A) && (base_char <= CHAR_LOW_Z);
        if (is_letter)
        begin
            // upper case is 0x20 below lower case
            char_code = (shift_held ^ caps_on) ? {base_char[6], 1'b0, base_char[4:0]}
                                               : base_char;
        end
        else if (shift_held)
        begin
            char_code = shifted_char(base_char);
        end
        else
        begin
            char_code = base_char;
        end
    end

endmodule

`default_nettype wire

/* rtl/ss1kd_decode.sv */
`default_nettype none

module ss1kd_decode (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        scan_byte,
    output ss1kd_pkg::result_t     result
);
    import ss1kd_pkg::*;

    logic       shift_reg,  shift_next;
    logic       caps_reg,   caps_next;
    logic       prefix_reg, prefix_next;
    logic [6:0] key;
    logic [6:0] table_char;
    logic       is_shift;

    assign key      = scan_byte[6:0];
    assign is_shift = (key == KEY_LSHIFT) || (key == KEY_RSHIFT);

    ss1kd_lookup u_lookup (
        .key        (key),
        .shift_held (shift_reg),
        .caps_on    (caps_reg),
        .char_code  (table_char)
    );

    always_comb
    begin
        shift_next        = shift_reg;
        caps_next         = caps_reg;
        prefix_next       = prefix_reg;
        result.valid      = 1'b0;
        result.event_code = EV_CHAR;
        result.char_code  = CHAR_NONE;

        if (scan_byte == PREFIX_BYTE)
        begin
            prefix_next = 1'b1;
        end
        else if (scan_byte[7])
        begin
            // release
            if (is_shift)
            begin
                shift_next = 1'b0;
            end
            prefix_next = 1'b0;
        end
        else if (prefix_reg)
        begin
            prefix_next  = 1'b0;
            result.valid = 1'b1;
            unique case (key)
                KEY_UP:     result.event_code = EV_UP;
                KEY_DOWN:   result.event_code = EV_DOWN;
                KEY_LEFT:   result.event_code = EV_LEFT;
                KEY_RIGHT:  result.event_code = EV_RIGHT;
                KEY_HOME:   result.event_code = EV_HOME;
                KEY_END:    result.event_code = EV_END;
                KEY_DELETE: result.event_code = EV_DELETE;
                default:    result.valid      = 1'b0;
            endcase
        end
        else if (is_shift)
        begin
            shift_next = 1'b1;
        end
        else if (key == KEY_CAPS)
        begin
            caps_next = ~caps_reg;
        end
        else
        begin
            result.valid     = (table_char != CHAR_NONE);
            result.char_code = table_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= 1'b0;
            caps_reg   <= 1'b0;
            prefix_reg <= 1'b0;
        end
        else if (step)
        begin
            shift_reg  <= shift_next;
            caps_reg   <= caps_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/scancode_set1_key_decoder_core.sv */
`default_nettype none

// set-1 keyboard scan byte decoder. each input word is one raw scan byte;
// each output word is either a character (event_code 0, ascii in char_code)
// or a navigation event (up, down, left, right, home, end, delete) with
// char_code zero. prefix bytes, releases, shift and caps keys and unmapped
// keys produce no output word. shift, caps lock and the 0xE0 prefix are held
// in flags that reset clears. an accepted byte waits in the input register
// until the result register can take a word, and then moves through the
// table lookup and flag logic into the result register. one byte per cycle
// is sustained as long as the output side is not stalled; while a result
// waits, one more byte can be taken into the input register, and after that
// the input side stalls until the result drains.
module scancode_set1_key_decoder_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         scan_byte,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output ss1kd_pkg::event_t       event_code,
    output logic [6:0]              char_code
);
    import ss1kd_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] byte_reg;

    // result register
    logic       out_valid_reg;
    event_t     event_reg;
    logic [6:0] char_reg;

    logic       step;
    logic       in_take;
    result_t    result;

    // the byte in the input register is decoded when the result register
    // can take a word (empty, or being drained this cycle)
    assign step     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !step;
    assign in_take  = in_valid && !in_stall;

    ss1kd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .scan_byte (byte_reg),
        .result    (result)
    );

    // input register: refills whenever it is empty or its byte moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_valid_reg || step)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= scan_byte;
        end
    end

    // result register: holds while the downstream side stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= step && result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && result.valid)
        begin
            event_reg <= result.event_code;
            char_reg  <= result.char_code;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = event_reg;
    assign char_code  = char_reg;

`ifndef SYNTHESIS
    // navigation events carry no character
    a_nav_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code != EV_CHAR) |-> char_code == CHAR_NONE)
        else $error("navigation word with nonzero char_code");

    // a character word is never the unmapped code
    a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code == EV_CHAR) |-> char_code != CHAR_NONE)
        else $error("character word with zero char_code");

    // input side stalls only while a byte waits in the input register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked byte");

    // a new word appears only from a decoded byte
    a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(step))
        else $error("output word without a decoded byte");
`endif

endmodule

`default_nettype wire
